FILE: design/lgsi_pkg.sv
// Shared types and constants for the linear gradient span interpolator.
// Used by lgsi_seq and the top level; depends on nothing.
`default_nettype none

package lgsi_pkg;

    localparam int NUM_CHAN      = 3;
    localparam int LEVEL_W       = 8;
    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int SPAN_BITS_DEF = 16;

    typedef logic [1:0] chan_idx_t;

    localparam chan_idx_t CHAN_RED   = 2'd0;
    localparam chan_idx_t CHAN_GREEN = 2'd1;
    localparam chan_idx_t CHAN_BLUE  = 2'd2;
    localparam chan_idx_t LAST_CHAN  = CHAN_BLUE;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_RED   = 3'd0,
        CFG_START_GREEN = 3'd1,
        CFG_START_BLUE  = 3'd2,
        CFG_END_RED     = 3'd3,
        CFG_END_GREEN   = 3'd4,
        CFG_END_BLUE    = 3'd5,
        CFG_SPAN_LENGTH = 3'd6
    } cfg_index_t;

    typedef logic [NUM_CHAN-1:0][LEVEL_W-1:0] color_vec_t;

    typedef struct packed {
        logic restart;
        logic in_clip;
    } in_item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
    } out_item_t;

    // Sequencer command, issued with an input transaction.
    typedef struct packed {
        logic go;
        logic init;
        logic uni;
    } seq_cmd_t;

endpackage

`default_nettype wire

FILE: design/lgsi_step_alu.sv
// Shared error unit: one adder and one greater-than-zero compare.
// No dependencies besides its parameter.
`default_nettype none

module lgsi_step_alu #(
    parameter int EW = 18
) (
    input  wire logic [EW-1:0] cmp_a,
    input  wire logic [EW-1:0] add_a,
    input  wire logic [EW-1:0] add_b,
    output logic      [EW-1:0] sum,
    output logic               a_pos
);

    assign sum   = add_a + add_b;
    assign a_pos = !cmp_a[EW-1] && (cmp_a != '0);

endmodule

`default_nettype wire

FILE: design/lgsi_seq.sv
// Channel state and step sequencer: walks red, green, blue through one
// Bresenham step each, sharing lgsi_step_alu. Depends on lgsi_pkg and lgsi_step_alu.
`default_nettype none

module lgsi_seq
    import lgsi_pkg::*;
#(
    parameter int SPAN_BITS = SPAN_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire seq_cmd_t             cmd,
    input  wire color_vec_t           start_hi,
    input  wire color_vec_t           end_hi,
    input  wire logic [SPAN_BITS-1:0] span,
    output logic                      busy,
    output color_vec_t                level
);

    localparam int EW = SPAN_BITS + 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_SUB
    } state_t;

    state_t                      state_reg, state_next;
    chan_idx_t                   chan_reg, chan_next;
    color_vec_t                  level_reg, level_next;
    logic [NUM_CHAN-1:0][EW-1:0] err_reg, err_next;
    logic [NUM_CHAN-1:0]         dir_reg, dir_next;

    chan_idx_t          nxt_chan;
    chan_idx_t          add_chan;
    logic [LEVEL_W-1:0] a_hi, b_hi, delta;
    logic               sub_op;
    logic [EW-1:0]      cur_err, add_a, add_b, sum;
    logic               pos;

    assign nxt_chan = chan_reg + 2'd1;
    assign add_chan = (state_reg == ST_ADD) ? chan_reg : nxt_chan;
    assign a_hi     = start_hi[add_chan];
    assign b_hi     = end_hi[add_chan];
    assign delta    = (a_hi > b_hi) ? (a_hi - b_hi) : (b_hi - a_hi);
    assign cur_err  = err_reg[chan_reg];
    assign sub_op   = (state_reg == ST_SUB) && pos;
    assign add_a    = sub_op ? cur_err : err_reg[add_chan];
    assign add_b    = sub_op ? -EW'(span) : EW'(delta);

    lgsi_step_alu #(
        .EW (EW)
    ) u_alu (
        .cmp_a (cur_err),
        .add_a (add_a),
        .add_b (add_b),
        .sum   (sum),
        .a_pos (pos)
    );

    always_comb begin
        state_next = state_reg;
        chan_next  = chan_reg;
        level_next = level_reg;
        err_next   = err_reg;
        dir_next   = dir_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.go) begin
                    if (cmd.init) begin
                        for (int k = 0; k < NUM_CHAN; k++) begin
                            level_next[k] = start_hi[k];
                            err_next[k]   = -EW'(span >> 1);
                            dir_next[k]   = end_hi[k] > start_hi[k];
                        end
                    end
                    if (!cmd.uni) begin
                        state_next = ST_ADD;
                        chan_next  = CHAN_RED;
                    end
                end
            end
            ST_ADD: begin
                err_next[chan_reg] = sum;
                state_next         = ST_SUB;
            end
            ST_SUB: begin
                if (pos) begin
                    // one level move per cycle while the error is positive
                    err_next[chan_reg]   = sum;
                    level_next[chan_reg] = dir_reg[chan_reg] ? level_reg[chan_reg] + 8'd1
                                                             : level_reg[chan_reg] - 8'd1;
                end else if (chan_reg == LAST_CHAN) begin
                    state_next = ST_IDLE;
                end else begin
                    // adder is free: fold in the next channel's delta now
                    err_next[nxt_chan] = sum;
                    chan_next          = nxt_chan;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            chan_reg  <= CHAN_RED;
            level_reg <= '0;
            err_reg   <= '0;
            dir_reg   <= '0;
        end else begin
            state_reg <= state_next;
            chan_reg  <= chan_next;
            level_reg <= level_next;
            err_reg   <= err_next;
            dir_reg   <= dir_next;
        end
    end

    assign busy  = (state_reg != ST_IDLE);
    assign level = level_reg;

    a_chan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> (chan_reg == CHAN_RED || chan_reg == CHAN_GREEN || chan_reg == CHAN_BLUE))
        else $error("channel index out of range");

    a_go_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (!busy && cmd.go && !cmd.uni) |=> (state_reg == ST_ADD && chan_reg == CHAN_RED))
        else $error("step sequence did not start");

    a_last_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SUB && !pos && chan_reg == LAST_CHAN) |=> !busy)
        else $error("sequencer did not finish after last channel");

    a_settled: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SUB && !pos && chan_reg != LAST_CHAN)
            |=> (state_reg == ST_SUB && !err_reg[$past(chan_reg)][EW-1] == 1'b0
                 || err_reg[$past(chan_reg)] == '0))
        else $error("finished channel left with positive error");

endmodule

`default_nettype wire

FILE: design/linear_gradient_span_interpolator_unit.sv
// Top level of the linear gradient span interpolator: configuration
// registers, input/result handshakes, result buffering. Depends on lgsi_pkg,
// lgsi_seq and lgsi_step_alu.
//
//  port group   dir  handshake            payload
//  s_*          in   s_valid / s_ready    in_item_t  {restart, in_clip}
//  m_*          out  m_valid / m_ready    out_item_t {red, green, blue}
//  cfg_*        in   cfg_wr_en (no wait)  cfg_index, cfg_wdata
//
// Steps: a uniform item (equal colors or span of 0 or 1) starts no step.
// Otherwise input waits for the step, one subtract per level move: the shared error
// adder in lgsi_seq does one add or subtract per cycle, channels in turn.
// Reset: aresetn low on a clock edge clears config, channel state, buffer valid flags.
// Stalls: a result waiting in the output register does not block input; a
// second one parks in a pending slot, and input also waits while that is full.
`default_nettype none

module linear_gradient_span_interpolator_unit
    import lgsi_pkg::*;
#(
    parameter int SPAN_BITS = SPAN_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // input channel
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire in_item_t             s_data,
    // result channel
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output out_item_t                 m_data,
    // configuration writes
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    // configuration registers
    logic [NUM_CHAN-1:0][CFG_W-1:0] start_reg, start_next;
    logic [NUM_CHAN-1:0][CFG_W-1:0] end_reg, end_next;
    logic [CFG_W-1:0]               span_reg, span_next;

    // result buffering: output register plus one pending slot
    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg, m_data_next;
    logic      pend_valid_reg, pend_valid_next;
    out_item_t pend_data_reg, pend_data_next;

    color_vec_t           start_hi, end_hi, level, emit;
    logic [SPAN_BITS-1:0] span_w;
    logic                 uni;
    logic                 busy;
    logic                 accept;
    logic                 out_free;
    seq_cmd_t             cmd;
    out_item_t            result;

    always_comb begin
        for (int k = 0; k < NUM_CHAN; k++) begin
            start_hi[k] = start_reg[k][CFG_W-1 -: LEVEL_W];
            end_hi[k]   = end_reg[k][CFG_W-1 -: LEVEL_W];
        end
    end

    // low SPAN_BITS of the span register; zero-extended when wider
    assign span_w = SPAN_BITS'(span_reg);

    // uniform: full 16-bit colors equal, or span at most 1
    assign uni = (start_reg == end_reg) || (span_w[SPAN_BITS-1:1] == '0);

    assign s_ready  = !busy && !pend_valid_reg;
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign cmd.go   = accept;
    assign cmd.init = s_data.restart;
    assign cmd.uni  = uni;

    // Color of this position is known at accept: a restart loads the start
    // bytes, which is also what uniform mode shows.
    always_comb begin
        for (int k = 0; k < NUM_CHAN; k++) begin
            emit[k] = (uni || s_data.restart) ? start_hi[k] : level[k];
        end
    end

    assign result.red   = emit[CHAN_RED];
    assign result.green = emit[CHAN_GREEN];
    assign result.blue  = emit[CHAN_BLUE];

    lgsi_seq #(
        .SPAN_BITS (SPAN_BITS)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .start_hi (start_hi),
        .end_hi   (end_hi),
        .span     (span_w),
        .busy     (busy),
        .level    (level)
    );

    // config write decode; index 7 is ignored
    always_comb begin
        start_next = start_reg;
        end_next   = end_reg;
        span_next  = span_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_START_RED:   start_next[CHAN_RED]   = cfg_wdata;
                CFG_START_GREEN: start_next[CHAN_GREEN] = cfg_wdata;
                CFG_START_BLUE:  start_next[CHAN_BLUE]  = cfg_wdata;
                CFG_END_RED:     end_next[CHAN_RED]     = cfg_wdata;
                CFG_END_GREEN:   end_next[CHAN_GREEN]   = cfg_wdata;
                CFG_END_BLUE:    end_next[CHAN_BLUE]    = cfg_wdata;
                CFG_SPAN_LENGTH: span_next              = cfg_wdata;
                default: ;
            endcase
        end
    end

    // Result path. Pending slot drains first; a new transaction is only
    // accepted while the slot is empty, so the two never collide.
    always_comb begin
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        pend_valid_next = pend_valid_reg;
        pend_data_next  = pend_data_reg;
        if (pend_valid_reg && out_free) begin
            m_valid_next    = 1'b1;
            m_data_next     = pend_data_reg;
            pend_valid_next = 1'b0;
        end else if (accept && s_data.in_clip) begin
            if (out_free) begin
                m_valid_next = 1'b1;
                m_data_next  = result;
            end else begin
                pend_valid_next = 1'b1;
                pend_data_next  = result;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg      <= '0;
            end_reg        <= '0;
            span_reg       <= '0;
            m_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            start_reg      <= start_next;
            end_reg        <= end_next;
            span_reg       <= span_next;
            m_valid_reg    <= m_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
        m_data_reg    <= m_data_next;
        pend_data_reg <= pend_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_pend_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_valid_reg && out_free) |=> !pend_valid_reg)
        else $error("pending result not moved to a free output");

    a_clip_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.in_clip) |=> (m_valid_reg || pend_valid_reg))
        else $error("in-clip transaction produced no result");

    a_no_busy_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !uni) |=> busy)
        else $error("non-uniform transaction did not start a step");

endmodule

`default_nettype wire
